// ===== hw/rtl/gbw_pkg.sv =====
// shared constants for the glyph bitplane writer
// no dependencies; imported by every module of the block
package gbw_pkg;

    localparam int FONT_BYTES_DEF  = 8192;
    localparam int LINE_STRIDE_DEF = 128;

    localparam int GLYPH_W     = 8;
    localparam int PLANE_W     = 2;
    localparam int SCAN_W      = 3;
    localparam int NUM_PLANES  = 4;
    localparam int FIDX_W      = 13;
    localparam int BYTE_W      = 8;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 7;
    localparam int ADDR_W      = 24;
    localparam int PLANE_SHIFT = 17;
    localparam int SCANLINES   = 8;

    localparam logic [ADDR_W-1:0] TEXT_BASE = 24'hE00000;
    localparam logic [SCAN_W-1:0] SCAN_LAST = 3'd7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // input tdata layout, lowest bit up
    localparam int IN_TDATA_W = 48;
    localparam int FIDX_LSB   = 0;
    localparam int FBYTE_LSB  = 13;
    localparam int COL_LSB    = 21;
    localparam int ROW_LSB    = 28;
    localparam int GLYPH_LSB  = 35;
    localparam int MASK_LSB   = 43;

    localparam int OUT_TDATA_W = 32;

endpackage

// ===== hw/rtl/gbw_font_mem.sv =====
// font store: single write port, one registered read port
// depends on gbw_pkg for the byte width
module gbw_font_mem #(
    parameter int DEPTH = gbw_pkg::FONT_BYTES_DEF,
    parameter int AW    = $clog2(gbw_pkg::FONT_BYTES_DEF)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [gbw_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [gbw_pkg::BYTE_W-1:0] rd_data
);
    import gbw_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/gbw_sequencer.sv =====
// request decode, draw walk over planes and scanlines, output stage control
// depends on gbw_pkg; drives the font store ports
module gbw_sequencer #(
    parameter int FONT_BYTES  = gbw_pkg::FONT_BYTES_DEF,
    parameter int LINE_STRIDE = gbw_pkg::LINE_STRIDE_DEF,
    parameter int AW          = $clog2(gbw_pkg::FONT_BYTES_DEF)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_op,
    input  logic [gbw_pkg::FIDX_W-1:0]     in_font_index,
    input  logic [gbw_pkg::BYTE_W-1:0]     in_font_byte,
    input  logic [gbw_pkg::COL_W-1:0]      in_column,
    input  logic [gbw_pkg::ROW_W-1:0]      in_text_row,
    input  logic [gbw_pkg::GLYPH_W-1:0]    in_glyph,
    input  logic [gbw_pkg::NUM_PLANES-1:0] in_plane_mask,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gbw_pkg::ADDR_W-1:0]     out_addr,
    output logic                           out_last,
    output logic                           mem_wr_en,
    output logic [AW-1:0]                  mem_wr_addr,
    output logic [gbw_pkg::BYTE_W-1:0]     mem_wr_data,
    output logic                           mem_rd_en,
    output logic [AW-1:0]                  mem_rd_addr
);
    import gbw_pkg::*;

    localparam int POS_W = (AW > FIDX_W) ? AW : FIDX_W;
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(SCANLINES * LINE_STRIDE);
    localparam logic [ADDR_W-1:0] LINE_STEP   = ADDR_W'(LINE_STRIDE);
    localparam logic [31:0]       STORE_BYTES = 32'(FONT_BYTES);

    function automatic logic [PLANE_W-1:0] lowest_plane(input logic [NUM_PLANES-1:0] m);
        logic [PLANE_W-1:0] sel;
        logic               found;
        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            if (m[i] && !found)
            begin
                sel   = PLANE_W'(i);
                found = 1'b1;
            end
        end
        return sel;
    endfunction

    logic                  active_reg, active_next;
    logic                  out_valid_reg, out_valid_next;
    logic [NUM_PLANES-1:0] mask_rem_reg, mask_rem_next;
    logic [SCAN_W-1:0]     scan_reg, scan_next;
    logic [GLYPH_W-1:0]    glyph_reg, glyph_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic                  out_last_reg, out_last_next;

    logic                  advance;
    logic                  issue;
    logic                  in_fire;
    logic [PLANE_W-1:0]    cur_plane;
    logic [NUM_PLANES-1:0] mask_done;
    logic [POS_W-1:0]      rd_pos;
    logic [POS_W-1:0]      wr_pos;

    assign in_ready  = !active_reg;
    assign in_fire   = in_valid && in_ready;
    assign advance   = !out_valid_reg || out_ready;
    assign issue     = active_reg && advance;
    assign cur_plane = lowest_plane(mask_rem_reg);
    assign mask_done = mask_rem_reg & ~(NUM_PLANES'(1) << cur_plane);

    // font position is glyph*32 + plane*8 + scanline
    assign rd_pos      = POS_W'({glyph_reg, cur_plane, scan_reg});
    assign mem_rd_addr = rd_pos[AW-1:0];
    assign mem_rd_en   = issue;

    // load request
    assign wr_pos      = POS_W'(in_font_index);
    assign mem_wr_addr = wr_pos[AW-1:0];
    assign mem_wr_data = in_font_byte;
    assign mem_wr_en   = in_fire && (in_op == OP_LOAD)
                         && ({19'd0, in_font_index} < STORE_BYTES);

    always_comb
    begin
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        mask_rem_next  = mask_rem_reg;
        scan_next      = scan_reg;
        glyph_next     = glyph_reg;
        base_next      = base_reg;
        out_addr_next  = out_addr_reg;
        out_last_next  = out_last_reg;

        if (issue)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = base_reg + (ADDR_W'(cur_plane) << PLANE_SHIFT)
                             + ADDR_W'(scan_reg) * LINE_STEP;
            out_last_next  = 1'b0;
            scan_next      = scan_reg + SCAN_W'(1);
            if (scan_reg == SCAN_LAST)
            begin
                mask_rem_next = mask_done;
                if (mask_done == '0)
                begin
                    active_next   = 1'b0;
                    out_last_next = 1'b1;
                end
            end
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire && (in_op == OP_DRAW) && (in_plane_mask != '0))
        begin
            active_next   = 1'b1;
            mask_rem_next = in_plane_mask;
            scan_next     = '0;
            glyph_next    = in_glyph;
            base_next     = TEXT_BASE + ADDR_W'(in_text_row) * ROW_STRIDE
                            + ADDR_W'(in_column);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_rem_reg <= mask_rem_next;
        scan_reg     <= scan_next;
        glyph_reg    <= glyph_next;
        base_reg     <= base_next;
        out_addr_reg <= out_addr_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/glyph_bitplane_writer_core.sv =====
// glyph bitplane writer top level: font store plus draw sequencer
// depends on gbw_pkg, gbw_font_mem and gbw_sequencer
//
//   channel  | direction | request
//   s_axis   | in        | font byte load (tuser 0) or glyph draw (tuser 1)
//   m_axis   | out       | one text plane byte write, tlast on the final write of a draw
//
// a load writes a single font store byte; a draw emits 8 writes per set
// mask bit (up to 32), one per cycle from the font store read port while
// m_axis accepts them; s_axis is held off until the last write of a draw
// is in the output register; m_axis stalls freeze the walk and the read
// register in place; reset clears control only, the font store stays undefined
// until loaded; FONT_BYTES is taken as a power of two
module glyph_bitplane_writer_core #(
    parameter int FONT_BYTES  = gbw_pkg::FONT_BYTES_DEF,
    parameter int LINE_STRIDE = gbw_pkg::LINE_STRIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // font_index[12:0], font_byte[20:13], column[27:21], text_row[34:28],
    // glyph[42:35], plane_mask[46:43], zero[47]
    input  logic [gbw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // write_address[23:0], write_data[31:24]
    output logic [gbw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);
    import gbw_pkg::*;

    localparam int FONT_AW = $clog2(FONT_BYTES);

    logic                  wr_en;
    logic [FONT_AW-1:0]    wr_addr;
    logic [BYTE_W-1:0]     wr_data;
    logic                  rd_en;
    logic [FONT_AW-1:0]    rd_addr;
    logic [BYTE_W-1:0]     rd_data;
    logic [ADDR_W-1:0]     out_addr;

    gbw_sequencer #(
        .FONT_BYTES  (FONT_BYTES),
        .LINE_STRIDE (LINE_STRIDE),
        .AW          (FONT_AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_op         (s_axis_tuser[0]),
        .in_font_index (s_axis_tdata[FIDX_LSB +: FIDX_W]),
        .in_font_byte  (s_axis_tdata[FBYTE_LSB +: BYTE_W]),
        .in_column     (s_axis_tdata[COL_LSB +: COL_W]),
        .in_text_row   (s_axis_tdata[ROW_LSB +: ROW_W]),
        .in_glyph      (s_axis_tdata[GLYPH_LSB +: GLYPH_W]),
        .in_plane_mask (s_axis_tdata[MASK_LSB +: NUM_PLANES]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_addr      (out_addr),
        .out_last      (m_axis_tlast),
        .mem_wr_en     (wr_en),
        .mem_wr_addr   (wr_addr),
        .mem_wr_data   (wr_data),
        .mem_rd_en     (rd_en),
        .mem_rd_addr   (rd_addr)
    );

    gbw_font_mem #(
        .DEPTH (FONT_BYTES),
        .AW    (FONT_AW)
    ) u_font (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_axis_tdata = {rd_data, out_addr};

endmodule
